// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Types and constants shared by the front decoder, the top level and the
// result sequencer of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder phase while scanning a string literal.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX,
    PH_HELD,
    PH_HELD_BS,
    PH_LOW_HEX
  } phase_t;

  // Kind code carried by each result word.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Main part of a decoded command, after an optional replacement character.
  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_BYTE,
    BODY_CP,
    BODY_DONE,
    BODY_ERR
  } body_t;

  localparam int CP_W = 21;

  // One command from the decoder: an optional U+FFFD prefix, then the body.
  typedef struct packed {
    logic              pre_fffd;
    body_t             body;
    logic [CP_W-1:0]   value;
  } cmd_t;

  // Characters the decoder looks for.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_U = 8'h75;

  // Code point constants.
  localparam logic [CP_W-1:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG = 6'b110111;

  // UTF-8 lead and continuation marks.
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT = 8'h80;

endpackage

// File: rtl/core/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes one JSON string literal from a byte stream into UTF-8 bytes,
// followed by a completion or error word.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle whenever in_stall is low. The
// front decoder classifies each byte in the cycle it is accepted and queues a
// command; the result sequencer then sends one output word per cycle while
// out_stall is low, so a byte that yields k words (up to six for a
// replacement character followed by a three-byte code point) holds the output
// side until all k are sent. The command queue of QUEUE_DEPTH entries absorbs
// such bursts; in_stall rises only when the queue is full. An accepted byte
// reaches its first word through the queue and then the output register.
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_kind,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_stall
);
  import jsu_pkg::*;

  logic accept;
  cmd_t push_cmd, head_cmd;
  logic push, pop, head_valid, q_full, front_idle;

  assign accept = in_valid && !in_stall;
  assign in_stall = q_full;

  jsu_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_data_byte(in_data_byte),
    .in_end_of_input(in_end_of_input),
    .accept(accept),
    .cmd(push_cmd),
    .cmd_push(push),
    .idle(front_idle)
  );

  jsu_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(push_cmd),
    .pop(pop),
    .head_data(head_cmd),
    .head_valid(head_valid),
    .full(q_full)
  );

  jsu_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head(head_cmd),
    .head_valid(head_valid),
    .pop(pop),
    .out_out_byte(out_out_byte),
    .out_kind(out_kind),
    .out_last(out_last),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  // A completion or error word always closes the results of its byte.
  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_last)
    else $error("completion or error word not marked last");

  // The decoder is idle after the final byte of a buffer.
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_input |=> front_idle)
    else $error("decoder not idle after final byte");

  // Input is held back only while commands are waiting.
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> head_valid)
    else $error("input stalled with an empty command queue");

endmodule

// File: rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescape front decoder
// Tracks the string-literal phase one byte per cycle while bytes are accepted
// and turns each byte into at most one command for the result sequencer.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_input,
  input  logic          accept,
  output jsu_pkg::cmd_t cmd,
  output logic          cmd_push,
  output logic          idle
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [7:0]  b;
  logic        is_quote, is_bslash, is_ws, is_u;
  logic        hv_ok;
  logic [3:0]  hv;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [15:0] unit;
  logic        unit_hi, unit_lo, last_digit;
  logic [CP_W-1:0] pair_cp;
  cmd_t        cmd_raw;

  assign b = in_data_byte;
  assign is_quote = (b == CH_QUOTE);
  assign is_bslash = (b == CH_BSLASH);
  assign is_u = (b == CH_LOW_U);
  assign is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);

  // Hex digit value.
  always_comb begin
    hv_ok = 1'b1;
    hv = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hv = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hv = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hv = 4'(b - 8'h37);
    end else begin
      hv_ok = 1'b0;
    end
  end

  // Single-character escapes.
  always_comb begin
    esc_ok = 1'b1;
    esc_byte = 8'h00;
    case (b)
      CH_QUOTE:  esc_byte = CH_QUOTE;
      CH_BSLASH: esc_byte = CH_BSLASH;
      CH_SLASH:  esc_byte = CH_SLASH;
      CH_LOW_B:  esc_byte = CH_BS;
      CH_LOW_F:  esc_byte = CH_FF;
      CH_LOW_N:  esc_byte = CH_LF;
      CH_LOW_R:  esc_byte = CH_CR;
      CH_LOW_T:  esc_byte = CH_TAB;
      default:   esc_ok = 1'b0;
    endcase
  end

  // The code unit completed by this byte when it is the fourth digit.
  assign unit = {acc_r, hv};
  assign unit_hi = (unit[15:10] == SURR_HIGH_TAG);
  assign unit_lo = (unit[15:10] == SURR_LOW_TAG);
  assign last_digit = (cnt_r == 2'd3);
  assign pair_cp = CP_W'({held_r, unit[9:0]}) + CP_SUPP_BASE;

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    held_nxt = held_r;
    cnt_nxt = cnt_r;
    case (phase_r)
      PH_IDLE: begin
        if (is_quote) phase_nxt = PH_STR;
      end
      PH_STR: begin
        if (is_quote) phase_nxt = PH_IDLE;
        else if (is_bslash) phase_nxt = PH_ESC;
      end
      PH_ESC: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (is_u) phase_nxt = PH_HEX;
        else if (esc_ok) phase_nxt = PH_STR;
        else phase_nxt = PH_IDLE;
      end
      PH_HEX, PH_LOW_HEX: begin
        if (!hv_ok) begin
          phase_nxt = PH_IDLE;
          acc_nxt = '0;
          cnt_nxt = '0;
          held_nxt = '0;
        end else if (last_digit) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          // A non-matching unit after a held high surrogate is decoded afresh.
          if (phase_r == PH_LOW_HEX && unit_lo) begin
            phase_nxt = PH_STR;
            held_nxt = '0;
          end else if (unit_hi) begin
            phase_nxt = PH_HELD;
            held_nxt = unit[9:0];
          end else begin
            phase_nxt = PH_STR;
            held_nxt = '0;
          end
        end else begin
          acc_nxt = {acc_r[7:0], hv};
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_HELD: begin
        if (is_bslash) begin
          phase_nxt = PH_HELD_BS;
        end else begin
          held_nxt = '0;
          phase_nxt = is_quote ? PH_IDLE : PH_STR;
        end
      end
      PH_HELD_BS: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (is_u) begin
          phase_nxt = PH_LOW_HEX;
        end else begin
          held_nxt = '0;
          phase_nxt = esc_ok ? PH_STR : PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // The final byte of the buffer always leaves the decoder idle.
    if (in_end_of_input || phase_nxt == PH_IDLE) begin
      phase_nxt = PH_IDLE;
      acc_nxt = '0;
      held_nxt = '0;
      cnt_nxt = '0;
    end
  end

  // Command for this byte.
  always_comb begin
    cmd_raw.pre_fffd = 1'b0;
    cmd_raw.body = BODY_NONE;
    cmd_raw.value = CP_W'(b);
    case (phase_r)
      PH_IDLE: begin
        if (!is_quote && !is_ws) cmd_raw.body = BODY_ERR;
      end
      PH_STR: begin
        if (is_quote) cmd_raw.body = BODY_DONE;
        else if (!is_bslash) cmd_raw.body = BODY_BYTE;
      end
      PH_ESC: begin
        cmd_raw.value = CP_W'(esc_byte);
        if (esc_ok) cmd_raw.body = BODY_BYTE;
        else if (!is_u) cmd_raw.body = BODY_ERR;
      end
      PH_HEX: begin
        if (!hv_ok) begin
          cmd_raw.body = BODY_ERR;
        end else if (last_digit && !unit_hi) begin
          cmd_raw.body = BODY_CP;
          cmd_raw.value = unit_lo ? CP_REPLACE : CP_W'(unit);
        end
      end
      PH_HELD: begin
        if (!is_bslash) begin
          cmd_raw.pre_fffd = 1'b1;
          cmd_raw.body = is_quote ? BODY_DONE : BODY_BYTE;
        end
      end
      PH_HELD_BS: begin
        if (!is_u) begin
          cmd_raw.pre_fffd = 1'b1;
          cmd_raw.value = CP_W'(esc_byte);
          cmd_raw.body = esc_ok ? BODY_BYTE : BODY_ERR;
        end
      end
      PH_LOW_HEX: begin
        if (!hv_ok) begin
          cmd_raw.pre_fffd = 1'b1;
          cmd_raw.body = BODY_ERR;
        end else if (last_digit) begin
          if (unit_lo) begin
            cmd_raw.body = BODY_CP;
            cmd_raw.value = pair_cp;
          end else begin
            cmd_raw.pre_fffd = 1'b1;
            if (!unit_hi) begin
              cmd_raw.body = BODY_CP;
              cmd_raw.value = CP_W'(unit);
            end
          end
        end
      end
      default: begin
        cmd_raw.body = BODY_NONE;
      end
    endcase
  end

  // A final byte that neither completes nor fails reports only an error.
  always_comb begin
    cmd = cmd_raw;
    if (in_end_of_input && cmd_raw.body != BODY_DONE && cmd_raw.body != BODY_ERR) begin
      cmd.pre_fffd = 1'b0;
      cmd.body = BODY_ERR;
    end
  end

  assign cmd_push = accept && (cmd.pre_fffd || cmd.body != BODY_NONE);
  assign idle = (phase_r == PH_IDLE);

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r <= '0;
      held_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r <= acc_nxt;
      held_r <= held_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescape command queue
// Small register queue that decouples the decoder from the result sequencer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             head_valid,
  output logic             full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_pop;

  assign head_data = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full = (count_r == FULL_COUNT);
  assign do_pop = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + CW'(1);
    else if (!push && do_pop) count_nxt = count_r - CW'(1);
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescape result sequencer
// Expands each queued command into its result words, one word per cycle while
// out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic [7:0]    out_out_byte,
  output logic [1:0]    out_kind,
  output logic          out_last,
  output logic          out_valid,
  input  logic          out_stall
);
  import jsu_pkg::*;

  logic [2:0] seq_r, seq_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  kind_t      kind_r;
  logic       last_r;

  logic [2:0] pre_len, body_len, total, q;
  logic [2:0] utf_len;
  logic [7:0] utf_byte [4];
  logic [7:0] w_byte;
  kind_t      w_kind;
  logic       w_last;
  logic       load;
  logic [CP_W-1:0] cp;

  assign cp = head.value;

  // UTF-8 encoding of the command's code point.
  always_comb begin
    utf_byte[1] = 8'h00;
    utf_byte[2] = 8'h00;
    utf_byte[3] = 8'h00;
    if (cp < 21'h80) begin
      utf_len = 3'd1;
      utf_byte[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      utf_len = 3'd2;
      utf_byte[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      utf_byte[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp < 21'h10000) begin
      utf_len = 3'd3;
      utf_byte[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
      utf_byte[1] = UTF8_CONT | {2'b00, cp[11:6]};
      utf_byte[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      utf_len = 3'd4;
      utf_byte[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      utf_byte[1] = UTF8_CONT | {2'b00, cp[17:12]};
      utf_byte[2] = UTF8_CONT | {2'b00, cp[11:6]};
      utf_byte[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
  end

  // Length of the command in result words.
  always_comb begin
    case (head.body)
      BODY_NONE: body_len = 3'd0;
      BODY_CP:   body_len = utf_len;
      default:   body_len = 3'd1;
    endcase
  end

  assign pre_len = head.pre_fffd ? 3'd3 : 3'd0;
  assign total = pre_len + body_len;
  assign q = seq_r - pre_len;

  // Result word at the current position of the command.
  always_comb begin
    w_byte = 8'h00;
    w_kind = KIND_DATA;
    if (seq_r < pre_len) begin
      case (seq_r[1:0])
        2'd0:    w_byte = 8'hEF;
        2'd1:    w_byte = 8'hBF;
        default: w_byte = 8'hBD;
      endcase
    end else begin
      case (head.body)
        BODY_BYTE: w_byte = cp[7:0];
        BODY_CP:   w_byte = utf_byte[q[1:0]];
        BODY_DONE: w_kind = KIND_DONE;
        BODY_ERR:  w_kind = KIND_ERR;
        default:   w_byte = 8'h00;
      endcase
    end
  end

  assign w_last = (seq_r == total - 3'd1);
  assign load = head_valid && (!valid_r || !out_stall);
  assign pop = load && w_last;
  assign seq_nxt = w_last ? 3'd0 : seq_r + 3'd1;

  // Position within the command and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) seq_r <= seq_nxt;
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= w_byte;
      kind_r <= w_kind;
      last_r <= w_last;
    end
  end

  assign out_valid = valid_r;
  assign out_out_byte = byte_r;
  assign out_kind = 2'(kind_r);
  assign out_last = last_r;

endmodule
